/* design/twpg_pkg.sv */
// shared types and constants for the three-waveform phase generator
package twpg_pkg;

  // full-scale sample magnitude of the 24-bit codec
  localparam int unsigned AMP = 8388607;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned MAG_BITS = 23;

  // quarter turn and unity in q30
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  // taylor divisors (2n)(2n+1) for n = 1..8
  localparam int unsigned TAYLOR_TERMS = 8;
  localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};

  // waveform select codes
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_RECT   = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_sel_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVE_SELECT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP  = 1'd1;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned STEP_BITS = 32;

endpackage

/* design/three_waveform_phase_generator.sv */
// three-waveform phase generator: phase accumulator, wave shaping and output register
//
// Usage: each word accepted on the input channel (in_valid high, in_stall low)
// produces one output word holding a left sample chosen by wave_select from the
// current phase, and its negation as the right sample. If in_advance is set the
// phase then moves on by phase_step, wrapping at 2^PHASE_BITS.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 wave_select,
// 1 phase_step) at the clock edge; write only while the block is idle.
// The output word is valid in the cycle after its input word is taken.
// Throughput: one word per cycle while no output word is held under out_stall; the
// phase register feeds the quarter-sine index multiply, table read and sign select
// straight into the output register.
// Stall: while an output word waits under out_stall, in_stall is raised and the
// phase holds; as soon as the word is taken a new input word is accepted in the
// same cycle.
// Reset: rst_n (synchronous, active low) clears the phase, both configuration
// registers (sine, zero step) and the output valid flag.
// The quarter-sine table has QUARTER_SINE_DEPTH+1 entries and is worked out at
// elaboration, so no fill pass follows reset.
module three_waveform_phase_generator #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned QUARTER_SINE_DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // configuration write port
  input  logic                                         cfg_we,
  input  logic [twpg_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [twpg_pkg::CFG_DATA_BITS-1:0]           cfg_wdata,
  // input channel
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         in_advance,
  // output channel
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic signed [twpg_pkg::SAMPLE_BITS-1:0]      out_left_sample,
  output logic signed [twpg_pkg::SAMPLE_BITS-1:0]      out_right_sample
);

  localparam int unsigned WITHIN_BITS = PHASE_BITS - 2;
  localparam int unsigned IDX_BITS = $clog2(QUARTER_SINE_DEPTH + 1);
  localparam int unsigned PROD_BITS = WITHIN_BITS + IDX_BITS;
  localparam int unsigned SB = twpg_pkg::SAMPLE_BITS;
  localparam int unsigned MB = twpg_pkg::MAG_BITS;

  // quarter-sine entry j, taylor series in q30, evaluated at elaboration
  function automatic logic [twpg_pkg::MAG_BITS-1:0] quarter_sine(input int unsigned j);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x = (64'(j) * twpg_pkg::QUARTER_TURN_Q30 + 64'(QUARTER_SINE_DEPTH / 2))
        / 64'(QUARTER_SINE_DEPTH);
    term = x;
    sum = x;
    for (int unsigned n = 1; n <= twpg_pkg::TAYLOR_TERMS; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(twpg_pkg::TAYLOR_DIV[n-1]);
      if (n % 2 == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'(twpg_pkg::AMP) + (twpg_pkg::Q30_ONE >> 1)) >> 30;
    if (v > 64'(twpg_pkg::AMP)) begin
      v = 64'(twpg_pkg::AMP);
    end
    return v[twpg_pkg::MAG_BITS-1:0];
  endfunction

  // configuration and state registers
  twpg_pkg::wave_sel_t               wave_select_r;
  logic [twpg_pkg::STEP_BITS-1:0]    phase_step_r;
  logic [PHASE_BITS-1:0]             phase_r;
  logic [PHASE_BITS-1:0]             phase_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [SB-1:0]              left_r;
  logic signed [SB-1:0]              right_r;
  logic signed [SB-1:0]              left_nxt;
  logic                              in_accept;

  // wave shaping signals
  logic [MB-1:0]          sine_tab [QUARTER_SINE_DEPTH+1];
  logic [1:0]             quadrant;
  logic [WITHIN_BITS-1:0] quad_phase;
  logic [PROD_BITS-1:0]   idx_prod;
  logic [IDX_BITS-1:0]    idx;
  logic [IDX_BITS-1:0]    idx_sel;
  logic [MB-1:0]          sine_mag;
  logic signed [SB-1:0]   sine_val;
  logic [31:0]            saw_t;
  logic [55:0]            saw_prod;
  logic signed [SB-1:0]   saw_val;
  logic signed [SB-1:0]   rect_val;

  // constant quarter-wave table
  for (genvar j = 0; j <= QUARTER_SINE_DEPTH; j++) begin : g_tab
    assign sine_tab[j] = quarter_sine(j);
  end

  // handshake
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // sine: quadrant, table index and mirror
  assign quadrant   = phase_r[PHASE_BITS-1 -: 2];
  assign quad_phase = phase_r[WITHIN_BITS-1:0];
  assign idx_prod   = PROD_BITS'(quad_phase) * PROD_BITS'(QUARTER_SINE_DEPTH);
  assign idx        = idx_prod[PROD_BITS-1:WITHIN_BITS];

  always_comb begin
    idx_sel = quadrant[0] ? (IDX_BITS'(QUARTER_SINE_DEPTH) - idx) : idx;
    sine_mag = sine_tab[idx_sel];
    sine_val = quadrant[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  end

  // sawtooth: phase scaled to 32 bits
  if (PHASE_BITS >= 32) begin : g_saw_down
    assign saw_t = phase_r[PHASE_BITS-1 -: 32];
  end else begin : g_saw_up
    assign saw_t = {phase_r, (32 - PHASE_BITS)'(0)};
  end

  assign saw_prod = 56'(saw_t) * 56'(2 * twpg_pkg::AMP);
  assign saw_val  = $signed(saw_prod[55:32]) - SB'(twpg_pkg::AMP);

  // rectangle: positive from half a turn on
  assign rect_val = phase_r[PHASE_BITS-1] ? $signed(SB'(twpg_pkg::AMP))
                                          : -$signed(SB'(twpg_pkg::AMP));

  // waveform select
  always_comb begin
    unique case (wave_select_r)
      twpg_pkg::WAVE_SINE:   left_nxt = sine_val;
      twpg_pkg::WAVE_RECT:   left_nxt = rect_val;
      twpg_pkg::WAVE_SAW:    left_nxt = saw_val;
      twpg_pkg::WAVE_SILENT: left_nxt = '0;
      default:               left_nxt = '0;
    endcase
  end

  // phase update and output valid
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept && in_advance) begin
      phase_nxt = phase_r + PHASE_BITS'(phase_step_r);
    end
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_select_r <= twpg_pkg::WAVE_SINE;
      phase_step_r  <= '0;
      phase_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          twpg_pkg::CFG_WAVE_SELECT: wave_select_r <= twpg_pkg::wave_sel_t'(cfg_wdata[1:0]);
          twpg_pkg::CFG_PHASE_STEP:  phase_step_r  <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output sample register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_r  <= left_nxt;
      right_r <= -left_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

  // right channel is always the negated left channel
  a_right_negated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (right_r == -left_r))
    else $error("right sample is not the negation of left sample");

  // samples never reach the most negative code
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (left_r != {1'b1, {(SB-1){1'b0}}}))
    else $error("left sample outside full scale");

  // an advancing word moves the phase by the step
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_advance && !cfg_we) |=>
      (phase_r == $past(phase_r + PHASE_BITS'(phase_step_r))))
    else $error("phase did not advance by the step");

  // a held word keeps the phase frozen
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_accept || !in_advance) |=> $stable(phase_r))
    else $error("phase moved without an advancing word");

endmodule
